@@ rtl/gir_pkg.sv @@
// Package for the grid incremental replanner: shared types, codes, constants
// and the key and neighbour helper functions. No dependencies.
`default_nettype none
package gir_pkg;

  localparam int CELLS      = 64;
  localparam int CELL_W     = 6;
  localparam int COST_W     = 8;
  localparam int KEY_W      = 22;
  localparam int ROWS_DEF   = 8;
  localparam int COLS_DEF   = 8;
  localparam int HEAP_DEF   = 256;
  localparam int MAX_PATH   = 64;
  localparam logic [12:0] POP_BUDGET = 13'd4096;
  localparam logic [7:0]  INF_COST   = 8'hFF;

  // command codes carried on in_tuser
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_INIT   = 3'd1;
  localparam logic [2:0] CMD_CHANGE = 3'd2;
  localparam logic [2:0] CMD_PLAN   = 3'd3;
  localparam logic [2:0] CMD_MOVE   = 3'd4;
  localparam logic [2:0] CMD_PATH   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOPATH = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;
  localparam logic [1:0] ST_TRUNC  = 2'd3;

  // configuration register indexes
  localparam logic REG_GOAL_ROW = 1'b0;
  localparam logic REG_GOAL_COL = 1'b1;

  typedef enum logic [2:0] {
    H_IDLE, H_UP, H_UP_FIN, H_DN_LAST, H_DN_CHK, H_DN_L, H_DN_R, H_DN_CMP
  } heap_st_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DONE, S_INIT, S_INIT_GOAL,
    S_UV_RD, S_UV_CHK, S_UV_NB, S_UV_NBRD, S_UV_WR, S_UV_PUSH,
    S_AR_NB, S_AR_RD,
    S_PL_TOP, S_PL_CMP, S_PL_U, S_PL_PUSH, S_PL_END_RD, S_PL_END,
    S_GP_RD, S_GP_CHK, S_GP_NB, S_GP_NBRD, S_EMIT
  } ctrl_st_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic              clr_ovf;
    logic [KEY_W-1:0]  key;
  } heap_req_t;

  typedef struct packed {
    logic              ready;
    logic              empty;
    logic              ovf;
    logic [KEY_W-1:0]  top;
  } heap_sts_t;

  typedef struct packed {
    logic [CELL_W-1:0] raddr;
    logic              obs_we;
    logic              cost_we;
    logic              clr_cost;
    logic [CELL_W-1:0] waddr;
    logic              obs;
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] rhs;
  } cell_req_t;

  typedef struct packed {
    logic              obs;
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] rhs;
  } cell_rd_t;

  typedef struct packed {
    logic              ok;
    logic [CELL_W-1:0] v;
  } nb_t;

  // cost plus one step, saturating at infinity
  function automatic logic [COST_W-1:0] sat_inc(input logic [COST_W-1:0] g);
    return (g >= 8'd254) ? INF_COST : g + 8'd1;
  endfunction

  // key {k1, k2, cell}: k2 = min(g, rhs), k1 = k2 + Manhattan distance to start
  function automatic logic [KEY_W-1:0] make_key(input logic [COST_W-1:0] g,
                                                input logic [COST_W-1:0] rhs,
                                                input logic [CELL_W-1:0] idx,
                                                input logic [CELL_W-1:0] st);
    logic [COST_W-1:0] m;
    logic [2:0]        dr;
    logic [2:0]        dc;
    logic [8:0]        k1;
    m  = (g < rhs) ? g : rhs;
    dr = (st[5:3] > idx[5:3]) ? st[5:3] - idx[5:3] : idx[5:3] - st[5:3];
    dc = (st[2:0] > idx[2:0]) ? st[2:0] - idx[2:0] : idx[2:0] - st[2:0];
    k1 = {1'b0, m} + {6'd0, dr} + {6'd0, dc};
    if (k1 > 9'd255) k1 = 9'd255;
    return {k1[7:0], m, idx};
  endfunction

  // neighbour k of a cell: down, up, right, left; ok when inside the grid
  function automatic nb_t nb_step(input logic [CELL_W-1:0] idx, input logic [1:0] k,
                                  input logic [3:0] rows, input logic [3:0] cols);
    logic [3:0] r;
    logic [3:0] c;
    logic [3:0] n;
    nb_t        res;
    r = {1'b0, idx[5:3]};
    c = {1'b0, idx[2:0]};
    res = '0;
    case (k)
      2'd0: begin
        n = r + 4'd1;
        res.ok = n < rows;
        res.v = {n[2:0], c[2:0]};
      end
      2'd1: begin
        n = r - 4'd1;
        res.ok = r != 4'd0;
        res.v = {n[2:0], c[2:0]};
      end
      2'd2: begin
        n = c + 4'd1;
        res.ok = n < cols;
        res.v = {r[2:0], n[2:0]};
      end
      default: begin
        n = c - 4'd1;
        res.ok = c != 4'd0;
        res.v = {r[2:0], n[2:0]};
      end
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/gir_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module gir_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write, then read the old contents on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/gir_cells.sv @@
// Per-cell store: obstacle bit and g/rhs costs in two RAMs, with valid bits
// that make unwritten cells read as free and infinite. Depends on gir_pkg, gir_ram.
`default_nettype none
module gir_cells
  import gir_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_req_t req,
  output cell_rd_t       rd
);

  logic [CELLS-1:0]      obs_vld_r;
  logic [CELLS-1:0]      cost_vld_r;
  logic                  ov_r;
  logic                  cv_r;
  logic                  obs_q;
  logic [2*COST_W-1:0]   cost_q;

  gir_ram #(.W(1), .D(CELLS)) u_obs (
    .clk(clk), .we(req.obs_we), .waddr(req.waddr), .wdata(req.obs),
    .raddr(req.raddr), .rdata(obs_q)
  );

  gir_ram #(.W(2*COST_W), .D(CELLS)) u_cost (
    .clk(clk), .we(req.cost_we), .waddr(req.waddr), .wdata({req.g, req.rhs}),
    .raddr(req.raddr), .rdata(cost_q)
  );

  // track which entries hold real data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obs_vld_r  <= '0;
      cost_vld_r <= '0;
    end else begin
      if (req.obs_we) obs_vld_r[req.waddr] <= 1'b1;
      if (req.clr_cost) begin
        cost_vld_r <= '0;
      end else if (req.cost_we) begin
        cost_vld_r[req.waddr] <= 1'b1;
      end
    end
  end

  // sample the valid bits alongside the RAM read
  always_ff @(posedge clk) begin
    ov_r <= obs_vld_r[req.raddr];
    cv_r <= cost_vld_r[req.raddr];
  end

  assign rd.obs = ov_r & obs_q;
  assign rd.g   = cv_r ? cost_q[2*COST_W-1:COST_W] : INF_COST;
  assign rd.rhs = cv_r ? cost_q[COST_W-1:0] : INF_COST;

endmodule
`default_nettype wire

@@ rtl/gir_heap.sv @@
// Binary min-heap of 22-bit keys in a RAM, one push or pop at a time with
// sift loops through its single read and write port. Depends on gir_pkg, gir_ram.
`default_nettype none
module gir_heap
  import gir_pkg::*;
#(
  parameter int HEAP_DEPTH = HEAP_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire heap_req_t req,
  output heap_sts_t      sts
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 1;

  heap_st_t         st_r, st_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    s_r, s_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] sv_r, sv_nxt;
  logic             ovf_r, ovf_nxt;
  logic [KEY_W-1:0] top_r;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [KEY_W-1:0] rdata;

  logic [IW-1:0]    lw;
  logic [IW-1:0]    rw;
  logic [IW-1:0]    cnt_x;
  logic [AW-1:0]    par;
  logic [CW-1:0]    cnt_dec;

  gir_ram #(.W(KEY_W), .D(HEAP_DEPTH)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign lw      = {idx_r, 1'b1};
  assign rw      = lw + IW'(1);
  assign cnt_x   = IW'(cnt_r);
  assign par     = (idx_r - AW'(1)) >> 1;
  assign cnt_dec = cnt_r - CW'(1);

  // sift sequencer
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    s_nxt   = s_r;
    key_nxt = key_r;
    sv_nxt  = sv_r;
    ovf_nxt = ovf_r;
    we      = 1'b0;
    waddr   = idx_r;
    wdata   = key_r;
    raddr   = '0;
    case (st_r)
      H_IDLE: begin
        if (req.clr_ovf) ovf_nxt = 1'b0;
        if (req.clear) begin
          cnt_nxt = '0;
        end else if (req.push) begin
          if (cnt_r >= CW'(HEAP_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
            key_nxt = req.key;
            if (cnt_r == '0) begin
              we    = 1'b1;
              waddr = '0;
              wdata = req.key;
            end else begin
              idx_nxt = cnt_r[AW-1:0];
              raddr   = (cnt_r[AW-1:0] - AW'(1)) >> 1;
              st_nxt  = H_UP;
            end
          end
        end else if (req.pop && cnt_r != '0) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec != '0) begin
            raddr  = cnt_dec[AW-1:0];
            st_nxt = H_DN_LAST;
          end
        end
      end
      H_UP: begin
        we = 1'b1;
        if (rdata <= key_r) begin
          st_nxt = H_IDLE;
        end else begin
          wdata   = rdata;
          idx_nxt = par;
          if (par == '0) begin
            st_nxt = H_UP_FIN;
          end else begin
            raddr = (par - AW'(1)) >> 1;
          end
        end
      end
      H_UP_FIN: begin
        we     = 1'b1;
        st_nxt = H_IDLE;
      end
      H_DN_LAST: begin
        key_nxt = rdata;
        idx_nxt = '0;
        st_nxt  = H_DN_CHK;
      end
      H_DN_CHK: begin
        if (lw >= cnt_x) begin
          we     = 1'b1;
          st_nxt = H_IDLE;
        end else begin
          raddr  = lw[AW-1:0];
          st_nxt = H_DN_L;
        end
      end
      H_DN_L: begin
        sv_nxt = rdata;
        s_nxt  = lw[AW-1:0];
        if (rw < cnt_x) begin
          raddr  = rw[AW-1:0];
          st_nxt = H_DN_R;
        end else begin
          st_nxt = H_DN_CMP;
        end
      end
      H_DN_R: begin
        if (rdata < sv_r) begin
          sv_nxt = rdata;
          s_nxt  = rw[AW-1:0];
        end
        st_nxt = H_DN_CMP;
      end
      H_DN_CMP: begin
        we = 1'b1;
        if (sv_r >= key_r) begin
          st_nxt = H_IDLE;
        end else begin
          wdata   = sv_r;
          idx_nxt = s_r;
          st_nxt  = H_DN_CHK;
        end
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= H_IDLE;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // follow every write to the root so the minimum is at hand whenever the heap is idle
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    s_r   <= s_nxt;
    key_r <= key_nxt;
    sv_r  <= sv_nxt;
    if (we && waddr == '0) top_r <= wdata;
  end

  assign sts.ready = (st_r == H_IDLE);
  assign sts.empty = (cnt_r == '0);
  assign sts.ovf   = ovf_r;
  assign sts.top   = top_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != H_IDLE |-> cnt_r != '0)
    else $error("heap sifting with no entries");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == H_IDLE && req.push && !req.clear && cnt_r == CW'(HEAP_DEPTH)) |=> ovf_r)
    else $error("push into full heap not flagged");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == H_IDLE && req.pop && !req.push && !req.clear && cnt_r != '0)
    |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("pop did not shrink heap");

endmodule
`default_nettype wire

@@ rtl/gir_ctrl.sv @@
// Command sequencer: decodes requests, runs vertex updates, the planning loop
// and the greedy path walk over the cell store and heap, and holds the result
// register. Depends on gir_pkg.
`default_nettype none
module gir_ctrl
  import gir_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [2:0]  in_row,
  input  wire logic [2:0]  in_col,
  input  wire logic        in_blk,
  input  wire logic [5:0]  goal,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_row,
  output logic [2:0]       out_col,
  output logic             out_last,
  output logic [1:0]       out_stat,
  output cell_req_t        creq,
  input  wire cell_rd_t    crd,
  output heap_req_t        hreq,
  input  wire heap_sts_t   hsts
);

  localparam logic [3:0] NR = 4'(ROWS);
  localparam logic [3:0] NC = 4'(COLS);

  ctrl_st_t          st_r, st_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [5:0]        start_r, start_nxt;
  logic [5:0]        u_r, u_nxt;
  logic [7:0]        gu_r, gu_nxt;
  logic [7:0]        mn_r, mn_nxt;
  logic [2:0]        kn_r, kn_nxt;
  logic [2:0]        ka_r, ka_nxt;
  logic [5:0]        ctr_r, ctr_nxt;
  logic              fromar_r, fromar_nxt;
  logic [5:0]        nbv_r, nbv_nxt;
  logic [KEY_W-1:0]  topk_r, topk_nxt;
  logic [KEY_W-1:0]  pk_r, pk_nxt;
  logic [12:0]       bud_r, bud_nxt;
  logic              budovf_r, budovf_nxt;
  logic [5:0]        cur_r, cur_nxt;
  logic [5:0]        nx_r, nx_nxt;
  logic [6:0]        n_r, n_nxt;
  logic              first_r, first_nxt;
  logic [5:0]        em_cell_r, em_cell_nxt;
  logic              em_last_r, em_last_nxt;
  logic [1:0]        em_stat_r, em_stat_nxt;
  logic              ov_r, ov_nxt;
  logic [5:0]        oc_r, oc_nxt;
  logic              ol_r, ol_nxt;
  logic [1:0]        os_r, os_nxt;

  logic              ovf;
  logic              ok_in;
  logic [5:0]        cell_in;
  nb_t               nb;
  logic [KEY_W-1:0]  kk;
  logic [7:0]        si;

  assign ovf      = hsts.ovf | budovf_r;
  assign ok_in    = ({1'b0, in_row} < NR) && ({1'b0, in_col} < NC);
  assign cell_in  = {in_row, in_col};
  assign in_ready = (st_r == S_IDLE) && hsts.ready;

  // next state and datapath of the sequencer
  always_comb begin
    st_nxt      = st_r;
    cmd_nxt     = cmd_r;
    start_nxt   = start_r;
    u_nxt       = u_r;
    gu_nxt      = gu_r;
    mn_nxt      = mn_r;
    kn_nxt      = kn_r;
    ka_nxt      = ka_r;
    ctr_nxt     = ctr_r;
    fromar_nxt  = fromar_r;
    nbv_nxt     = nbv_r;
    topk_nxt    = topk_r;
    pk_nxt      = pk_r;
    bud_nxt     = bud_r;
    budovf_nxt  = budovf_r;
    cur_nxt     = cur_r;
    nx_nxt      = nx_r;
    n_nxt       = n_r;
    first_nxt   = first_r;
    em_cell_nxt = em_cell_r;
    em_last_nxt = em_last_r;
    em_stat_nxt = em_stat_r;
    ov_nxt      = ov_r & ~out_ready;
    oc_nxt      = oc_r;
    ol_nxt      = ol_r;
    os_nxt      = os_r;
    creq        = '0;
    hreq        = '0;
    nb          = '0;
    kk          = '0;
    si          = '0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt      = in_cmd;
          hreq.clr_ovf = 1'b1;
          budovf_nxt   = 1'b0;
          u_nxt        = cell_in;
          ctr_nxt      = cell_in;
          fromar_nxt   = 1'b0;
          st_nxt       = S_DONE;
          case (in_cmd)
            CMD_LOAD: begin
              if (ok_in) begin
                creq.obs_we = 1'b1;
                creq.waddr  = cell_in;
                creq.obs    = in_blk;
              end
            end
            CMD_INIT: begin
              if (ok_in) begin
                start_nxt = cell_in;
                st_nxt    = S_INIT;
              end
            end
            CMD_CHANGE: begin
              if (ok_in) begin
                creq.obs_we = 1'b1;
                creq.waddr  = cell_in;
                creq.obs    = in_blk;
                st_nxt      = S_UV_RD;
              end
            end
            CMD_PLAN: begin
              bud_nxt = POP_BUDGET;
              st_nxt  = S_PL_TOP;
            end
            CMD_MOVE: begin
              if (ok_in) begin
                start_nxt = cell_in;
                bud_nxt   = POP_BUDGET;
                st_nxt    = S_PL_TOP;
              end
            end
            CMD_PATH: begin
              cur_nxt   = start_r;
              n_nxt     = 7'd1;
              first_nxt = 1'b1;
              st_nxt    = S_GP_RD;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      // single result with zero cell
      S_DONE: begin
        em_cell_nxt = '0;
        em_last_nxt = 1'b1;
        em_stat_nxt = ovf ? ST_OVF : ST_OK;
        st_nxt      = S_EMIT;
      end
      S_INIT: begin
        creq.clr_cost = 1'b1;
        hreq.clear    = 1'b1;
        st_nxt        = S_INIT_GOAL;
      end
      S_INIT_GOAL: begin
        creq.cost_we = 1'b1;
        creq.waddr   = goal;
        creq.g       = INF_COST;
        creq.rhs     = '0;
        hreq.push    = 1'b1;
        hreq.key     = make_key(INF_COST, 8'd0, goal, start_r);
        st_nxt       = S_DONE;
      end
      // vertex update of u_r
      S_UV_RD: begin
        creq.raddr = u_r;
        st_nxt     = S_UV_CHK;
      end
      S_UV_CHK: begin
        gu_nxt = crd.g;
        mn_nxt = INF_COST;
        kn_nxt = '0;
        if (u_r == goal) begin
          mn_nxt = crd.rhs;
          st_nxt = S_UV_PUSH;
        end else if (crd.obs) begin
          st_nxt = S_UV_WR;
        end else begin
          st_nxt = S_UV_NB;
        end
      end
      S_UV_NB: begin
        if (kn_r[2]) begin
          st_nxt = S_UV_WR;
        end else begin
          nb = nb_step(u_r, kn_r[1:0], NR, NC);
          if (nb.ok) begin
            creq.raddr = nb.v;
            st_nxt     = S_UV_NBRD;
          end else begin
            kn_nxt = kn_r + 3'd1;
          end
        end
      end
      S_UV_NBRD: begin
        si = sat_inc(crd.g);
        if (!crd.obs && si < mn_r) mn_nxt = si;
        kn_nxt = kn_r + 3'd1;
        st_nxt = S_UV_NB;
      end
      S_UV_WR: begin
        creq.cost_we = 1'b1;
        creq.waddr   = u_r;
        creq.g       = gu_r;
        creq.rhs     = mn_r;
        st_nxt       = S_UV_PUSH;
      end
      S_UV_PUSH: begin
        if (gu_r == mn_r || hsts.ready) begin
          if (gu_r != mn_r) begin
            hreq.push = 1'b1;
            hreq.key  = make_key(gu_r, mn_r, u_r, start_r);
          end
          ka_nxt = fromar_r ? ka_r + 3'd1 : 3'd0;
          st_nxt = S_AR_NB;
        end
      end
      // update the free neighbours of ctr_r
      S_AR_NB: begin
        if (ka_r[2]) begin
          st_nxt = (cmd_r == CMD_CHANGE) ? S_DONE : S_PL_TOP;
        end else begin
          nb = nb_step(ctr_r, ka_r[1:0], NR, NC);
          if (nb.ok) begin
            creq.raddr = nb.v;
            nbv_nxt    = nb.v;
            st_nxt     = S_AR_RD;
          end else begin
            ka_nxt = ka_r + 3'd1;
          end
        end
      end
      S_AR_RD: begin
        if (!crd.obs) begin
          u_nxt      = nbv_r;
          fromar_nxt = 1'b1;
          st_nxt     = S_UV_RD;
        end else begin
          ka_nxt = ka_r + 3'd1;
          st_nxt = S_AR_NB;
        end
      end
      // planning loop
      S_PL_TOP: begin
        if (hsts.ready) begin
          if (hsts.empty) begin
            st_nxt = S_PL_END_RD;
          end else if (bud_r == '0) begin
            budovf_nxt = 1'b1;
            st_nxt     = S_PL_END_RD;
          end else begin
            bud_nxt    = bud_r - 13'd1;
            topk_nxt   = hsts.top;
            creq.raddr = start_r;
            st_nxt     = S_PL_CMP;
          end
        end
      end
      S_PL_CMP: begin
        kk = make_key(crd.g, crd.rhs, start_r, start_r);
        if (topk_r[KEY_W-1:6] >= kk[KEY_W-1:6] && crd.rhs == crd.g) begin
          st_nxt = S_PL_END_RD;
        end else begin
          hreq.pop   = 1'b1;
          creq.raddr = topk_r[5:0];
          u_nxt      = topk_r[5:0];
          ctr_nxt    = topk_r[5:0];
          fromar_nxt = 1'b0;
          st_nxt     = S_PL_U;
        end
      end
      S_PL_U: begin
        kk = make_key(crd.g, crd.rhs, u_r, start_r);
        if (topk_r[KEY_W-1:6] < kk[KEY_W-1:6]) begin
          pk_nxt = kk;
          st_nxt = S_PL_PUSH;
        end else if (crd.g > crd.rhs) begin
          creq.cost_we = 1'b1;
          creq.waddr   = u_r;
          creq.g       = crd.rhs;
          creq.rhs     = crd.rhs;
          ka_nxt       = '0;
          st_nxt       = S_AR_NB;
        end else begin
          creq.cost_we = 1'b1;
          creq.waddr   = u_r;
          creq.g       = INF_COST;
          creq.rhs     = crd.rhs;
          st_nxt       = S_UV_RD;
        end
      end
      S_PL_PUSH: begin
        if (hsts.ready) begin
          hreq.push = 1'b1;
          hreq.key  = pk_r;
          st_nxt    = S_PL_TOP;
        end
      end
      S_PL_END_RD: begin
        creq.raddr = start_r;
        st_nxt     = S_PL_END;
      end
      S_PL_END: begin
        em_cell_nxt = '0;
        em_last_nxt = 1'b1;
        em_stat_nxt = ovf ? ST_OVF : ((crd.g == INF_COST) ? ST_NOPATH : ST_OK);
        st_nxt      = S_EMIT;
      end
      // greedy path walk
      S_GP_RD: begin
        creq.raddr = cur_r;
        st_nxt     = S_GP_CHK;
      end
      S_GP_CHK: begin
        first_nxt   = 1'b0;
        em_cell_nxt = cur_r;
        em_last_nxt = 1'b1;
        em_stat_nxt = ST_OK;
        mn_nxt      = INF_COST;
        nx_nxt      = cur_r;
        kn_nxt      = '0;
        st_nxt      = S_EMIT;
        if (first_r && crd.g == INF_COST) begin
          em_cell_nxt = '0;
          em_stat_nxt = ST_NOPATH;
        end else if (cur_r == goal) begin
          em_stat_nxt = ST_OK;
        end else if (n_r >= 7'(MAX_PATH)) begin
          em_stat_nxt = ST_TRUNC;
        end else if (crd.obs) begin
          em_stat_nxt = ST_NOPATH;
        end else begin
          st_nxt = S_GP_NB;
        end
      end
      S_GP_NB: begin
        if (kn_r[2]) begin
          em_cell_nxt = cur_r;
          st_nxt      = S_EMIT;
          if (nx_r == cur_r) begin
            em_last_nxt = 1'b1;
            em_stat_nxt = ST_NOPATH;
          end else begin
            em_last_nxt = 1'b0;
            em_stat_nxt = ST_OK;
            cur_nxt     = nx_r;
            n_nxt       = n_r + 7'd1;
          end
        end else begin
          nb = nb_step(cur_r, kn_r[1:0], NR, NC);
          if (nb.ok) begin
            creq.raddr = nb.v;
            nbv_nxt    = nb.v;
            st_nxt     = S_GP_NBRD;
          end else begin
            kn_nxt = kn_r + 3'd1;
          end
        end
      end
      S_GP_NBRD: begin
        si = sat_inc(crd.g);
        if (!crd.obs && si < mn_r) begin
          mn_nxt = si;
          nx_nxt = nbv_r;
        end
        kn_nxt = kn_r + 3'd1;
        st_nxt = S_GP_NB;
      end
      // hand the result to the output register once it is free
      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          oc_nxt = em_cell_r;
          ol_nxt = em_last_r;
          os_nxt = em_stat_r;
          st_nxt = em_last_r ? S_IDLE : S_GP_RD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      start_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      start_r <= start_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    u_r       <= u_nxt;
    gu_r      <= gu_nxt;
    mn_r      <= mn_nxt;
    kn_r      <= kn_nxt;
    ka_r      <= ka_nxt;
    ctr_r     <= ctr_nxt;
    fromar_r  <= fromar_nxt;
    nbv_r     <= nbv_nxt;
    topk_r    <= topk_nxt;
    pk_r      <= pk_nxt;
    bud_r     <= bud_nxt;
    budovf_r  <= budovf_nxt;
    cur_r     <= cur_nxt;
    nx_r      <= nx_nxt;
    n_r       <= n_nxt;
    first_r   <= first_nxt;
    em_cell_r <= em_cell_nxt;
    em_last_r <= em_last_nxt;
    em_stat_r <= em_stat_nxt;
    oc_r      <= oc_nxt;
    ol_r      <= ol_nxt;
    os_r      <= os_nxt;
  end

  assign out_valid = ov_r;
  assign out_row   = oc_r[5:3];
  assign out_col   = oc_r[2:0];
  assign out_last  = ol_r;
  assign out_stat  = os_r;

endmodule
`default_nettype wire

@@ rtl/grid_incremental_replanner_top.sv @@
// Grid incremental replanner (D* Lite style, 4-connected, no km term). Plan
// and move run one pop per pass of the planning loop. A pass waits for the heap
// sift, and a pass that settles a cell adds the neighbour updates. A plan makes
// up to 4096 pops. Get path emits the cells of the greedy walk one by one. The
// single read port of the cell store and of the heap RAM sets the pace. Results
// wait in one output register while the block goes on. No clearing pass: valid
// bits cover the cell store.
// Depends on gir_pkg, gir_ctrl, gir_cells, gir_heap.
`default_nettype none
module grid_incremental_replanner_top
  import gir_pkg::*;
#(
  parameter int ROWS       = ROWS_DEF,
  parameter int COLS       = COLS_DEF,
  parameter int HEAP_DEPTH = HEAP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // row[2:0], col[5:3], blocked[6], zero[7]
  input  wire logic [2:0] in_tuser,   // command[2:0]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // out_row[2:0], out_col[5:3], status[7:6]
  output logic            out_tlast,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_addr,
  input  wire logic [2:0] cfg_data
);

  logic [2:0] goal_row_r;
  logic [2:0] goal_col_r;
  cell_req_t  creq;
  cell_rd_t   crd;
  heap_req_t  hreq;
  heap_sts_t  hsts;
  logic [2:0] o_row;
  logic [2:0] o_col;
  logic [1:0] o_stat;

  // goal registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_row_r <= 3'd7;
      goal_col_r <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_GOAL_ROW: goal_row_r <= cfg_data;
        REG_GOAL_COL: goal_col_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gir_ctrl #(.ROWS(ROWS), .COLS(COLS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd(in_tuser),
    .in_row(in_tdata[2:0]), .in_col(in_tdata[5:3]), .in_blk(in_tdata[6]),
    .goal({goal_row_r, goal_col_r}),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_row(o_row), .out_col(o_col), .out_last(out_tlast), .out_stat(o_stat),
    .creq(creq), .crd(crd), .hreq(hreq), .hsts(hsts)
  );

  gir_cells u_cells (
    .clk(clk), .rst_n(rst_n), .req(creq), .rd(crd)
  );

  gir_heap #(.HEAP_DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .rst_n(rst_n), .req(hreq), .sts(hsts)
  );

  assign out_tdata = {o_stat, o_col, o_row};

endmodule
`default_nettype wire
